// ===== hw/rtl/ilist_pkg.sv =====
// ----------------------------------------------------------------------------
// ilist_pkg
// Shared types, sizes and codes of the indexed list insert/delete unit.
// ----------------------------------------------------------------------------
package ilist_pkg;

    localparam int CAPACITY = 32;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 8;
    localparam int VAL_W    = 32;
    localparam int OPOS_W   = 6;
    localparam int OP_W     = 3;
    localparam int STAT_W   = 3;

    localparam logic [OP_W-1:0] OP_APPEND    = 3'd0;
    localparam logic [OP_W-1:0] OP_PREPEND   = 3'd1;
    localparam logic [OP_W-1:0] OP_INSERT_AT = 3'd2;
    localparam logic [OP_W-1:0] OP_DELETE_AT = 3'd3;
    localparam logic [OP_W-1:0] OP_DUMP      = 3'd4;

    localparam logic [STAT_W-1:0] STAT_DONE  = 3'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE = 3'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 3'd2;
    localparam logic [STAT_W-1:0] STAT_ELEM  = 3'd3;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_FILL,
        ST_RESP,
        ST_DUMP
    } ctrl_state_t;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [VAL_W-1:0] wr_data;
    } mem_req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [VAL_W-1:0]  out_value;
        logic [OPOS_W-1:0] out_position;
        logic              last;
    } result_t;

endpackage

// ===== hw/rtl/ilist_mem.sv =====
// ----------------------------------------------------------------------------
// ilist_mem
// Element store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ilist_mem (
    input  logic                              aclk,
    input  ilist_pkg::mem_req_t               req,
    output logic [ilist_pkg::VAL_W-1:0]       rd_data
);
    import ilist_pkg::*;

    logic [VAL_W-1:0] store_mem [CAPACITY];

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            store_mem[req.wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data <= store_mem[req.rd_addr];
        end
    end

endmodule

// ===== hw/rtl/ilist_ctrl.sv =====
// ----------------------------------------------------------------------------
// ilist_ctrl
// Sequencer: decodes an item, shifts entries through the store one per
// cycle, streams dump elements and hands results to the output register.
// ----------------------------------------------------------------------------
module ilist_ctrl (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [ilist_pkg::OP_W-1:0]        in_op,
    input  logic [ilist_pkg::POS_W-1:0]       in_position,
    input  logic [ilist_pkg::VAL_W-1:0]       in_value,
    output ilist_pkg::mem_req_t               mem_req,
    input  logic [ilist_pkg::VAL_W-1:0]       mem_rd_data,
    input  logic                              res_free,
    output logic                              res_load,
    output ilist_pkg::result_t                res
);
    import ilist_pkg::*;

    ctrl_state_t       state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  pos_reg, pos_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [VAL_W-1:0]  val_reg, val_next;
    logic              del_reg, del_next;
    logic [STAT_W-1:0] stat_reg, stat_next;

    logic [POS_W-1:0]  ins_pos;
    logic [POS_W-1:0]  count_ext;
    logic [CNT_W-1:0]  idx_plus;
    logic              more;
    logic              dump_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg  <= pos_next;
        idx_reg  <= idx_next;
        val_reg  <= val_next;
        del_reg  <= del_next;
        stat_reg <= stat_next;
    end

    assign count_ext = POS_W'(count_reg);
    assign idx_plus  = CNT_W'(idx_reg) + CNT_W'(1);
    assign dump_last = (idx_plus == count_reg);

    always_comb begin
        unique case (in_op)
            OP_APPEND:  ins_pos = count_ext;
            OP_PREPEND: ins_pos = '0;
            default:    ins_pos = in_position;
        endcase
    end

    always_comb begin
        if (del_reg) begin
            more = (idx_plus < count_reg);
        end else begin
            more = (idx_reg > pos_reg);
        end
    end

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        idx_next   = idx_reg;
        val_next   = val_reg;
        del_next   = del_reg;
        stat_next  = stat_reg;
        in_ready   = 1'b0;
        mem_req    = '0;
        res_load   = 1'b0;
        res        = '0;

        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    unique case (in_op)
                        OP_APPEND, OP_PREPEND, OP_INSERT_AT: begin
                            if (ins_pos > count_ext) begin
                                stat_next  = STAT_RANGE;
                                state_next = ST_RESP;
                            end else if (count_reg == CNT_W'(CAPACITY)) begin
                                stat_next  = STAT_FULL;
                                state_next = ST_RESP;
                            end else begin
                                pos_next = IDX_W'(ins_pos);
                                val_next = in_value;
                                del_next = 1'b0;
                                if (count_ext > ins_pos) begin
                                    idx_next        = IDX_W'(count_reg - CNT_W'(1));
                                    mem_req.rd_en   = 1'b1;
                                    mem_req.rd_addr = IDX_W'(count_reg - CNT_W'(1));
                                    state_next      = ST_SHIFT;
                                end else begin
                                    state_next = ST_FILL;
                                end
                            end
                        end
                        OP_DELETE_AT: begin
                            if (in_position >= count_ext) begin
                                stat_next  = STAT_RANGE;
                                state_next = ST_RESP;
                            end else begin
                                pos_next = IDX_W'(in_position);
                                del_next = 1'b1;
                                if (in_position + POS_W'(1) < count_ext) begin
                                    idx_next        = IDX_W'(in_position + POS_W'(1));
                                    mem_req.rd_en   = 1'b1;
                                    mem_req.rd_addr = IDX_W'(in_position + POS_W'(1));
                                    state_next      = ST_SHIFT;
                                end else begin
                                    count_next = count_reg - CNT_W'(1);
                                    stat_next  = STAT_DONE;
                                    state_next = ST_RESP;
                                end
                            end
                        end
                        OP_DUMP: begin
                            if (count_reg == '0) begin
                                stat_next  = STAT_EMPTY;
                                state_next = ST_RESP;
                            end else begin
                                idx_next        = '0;
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = '0;
                                state_next      = ST_DUMP;
                            end
                        end
                        default: begin
                            stat_next  = STAT_DONE;
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end

            ST_SHIFT: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_data = mem_rd_data;
                mem_req.wr_addr = del_reg ? (idx_reg - IDX_W'(1)) : (idx_reg + IDX_W'(1));
                if (more) begin
                    idx_next        = del_reg ? (idx_reg + IDX_W'(1)) : (idx_reg - IDX_W'(1));
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = idx_next;
                end else if (del_reg) begin
                    count_next = count_reg - CNT_W'(1);
                    stat_next  = STAT_DONE;
                    state_next = ST_RESP;
                end else begin
                    state_next = ST_FILL;
                end
            end

            ST_FILL: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = pos_reg;
                mem_req.wr_data = val_reg;
                count_next      = count_reg + CNT_W'(1);
                stat_next       = STAT_DONE;
                state_next      = ST_RESP;
            end

            ST_RESP: begin
                if (res_free) begin
                    res_load   = 1'b1;
                    res.status = stat_reg;
                    res.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_DUMP: begin
                if (res_free) begin
                    res_load         = 1'b1;
                    res.status       = STAT_ELEM;
                    res.out_value    = mem_rd_data;
                    res.out_position = OPOS_W'(idx_reg);
                    res.last         = dump_last;
                    if (dump_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next        = idx_reg + IDX_W'(1);
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = idx_reg + IDX_W'(1);
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/indexed_list_insert_delete_unit.sv =====
// ----------------------------------------------------------------------------
// indexed_list_insert_delete_unit
// Ordered list of up to 32 signed 32-bit values with append, prepend,
// insert and delete at an index, and dump of the whole list.
// ----------------------------------------------------------------------------
// One item is taken at a time. Every op but dump gives one status item;
// dump gives one item per element (tlast on the final one) or one empty
// status. An insert or a delete at index p moves the entries behind p one
// per cycle through the single read and single write port of the element
// store; once the first element is read, a dump streams one element per
// cycle while m_tready does not hold the output register. Rejected and
// undefined ops go straight to the status response. The result sits in an
// output register, so the next item is taken while it waits on m_tready.
module indexed_list_insert_delete_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [2:0]  s_tuser,   // op
    input  logic [39:0] s_tdata,   // position[7:0], item_value[39:8]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [2:0]  m_tuser,   // status
    output logic [39:0] m_tdata,   // out_value[31:0], out_position[37:32], zero fill
    output logic        m_tlast
);
    import ilist_pkg::*;

    mem_req_t         mem_req;
    logic [VAL_W-1:0] mem_rd_data;
    logic             res_free;
    logic             res_load;
    result_t          res;

    logic             out_valid_reg;
    result_t          out_res_reg;

    ilist_mem u_mem (
        .aclk    (aclk),
        .req     (mem_req),
        .rd_data (mem_rd_data)
    );

    ilist_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_op       (s_tuser),
        .in_position (s_tdata[7:0]),
        .in_value    (s_tdata[39:8]),
        .mem_req     (mem_req),
        .mem_rd_data (mem_rd_data),
        .res_free    (res_free),
        .res_load    (res_load),
        .res         (res)
    );

    assign res_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.status;
    assign m_tdata  = {2'b00, out_res_reg.out_position, out_res_reg.out_value};
    assign m_tlast  = out_res_reg.last;

endmodule
